@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro wraps one concurrent assertion on clk, idle while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent at the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ssm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared constants, register codes and types of the stop string matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int NUM_PATTERNS_DEF    = 4;
  localparam int MAX_PATTERN_LEN_DEF = 8;
  localparam int OFFSET_BITS_DEF     = 16;

  // patterns backed by configuration registers
  localparam int REG_PATTERNS = 4;
  localparam int PATTERN_W    = 64;
  localparam int LENGTHS_W    = 16;
  localparam int LEN_W        = 4;
  localparam int HOLD_W       = 3;
  localparam int STOP_OFS_W   = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_A       = 3'd0,
    CFG_PATTERN_B       = 3'd1,
    CFG_PATTERN_C       = 3'd2,
    CFG_PATTERN_D       = 3'd3,
    CFG_PATTERN_LENGTHS = 3'd4
  } cfg_reg_t;

  // Per-byte outcome of the comparator array
  typedef struct packed {
    logic [LEN_W-1:0]  full_len;  // longest full match ending here, 0 = none
    logic [HOLD_W-1:0] hold;      // longest proper prefix at the text end
  } ssm_match_t;

endpackage

@@ hw/rtl/ssm_match.sv @@
// ----------------------------------------------------------------------------
// ssm_match
// Parallel comparators of every pattern prefix against the recent text window.
// ----------------------------------------------------------------------------
module ssm_match import ssm_pkg::*; #(
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  logic [MAX_PATTERN_LEN-1:0][7:0]        window,   // [0] is the newest byte
  input  logic [LEN_W-1:0]                       depth,    // bytes of text available
  input  logic [REG_PATTERNS-1:0][PATTERN_W-1:0] patterns,
  input  logic [LENGTHS_W-1:0]                   lengths,
  output ssm_match_t                             result
);

  always_comb begin
    logic [LEN_W-1:0] n;
    logic             hit;
    result = '0;
    for (int p = 0; p < REG_PATTERNS; p++) begin
      n = lengths[LEN_W*p +: LEN_W];
      if (n > LEN_W'(MAX_PATTERN_LEN)) begin
        n = LEN_W'(MAX_PATTERN_LEN);
      end
      if (p >= NUM_PATTERNS) begin
        n = '0;
      end
      for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
        // last l text bytes against the first l pattern bytes
        hit = (LEN_W'(l) <= n) && (LEN_W'(l) <= depth);
        for (int j = 0; j < l; j++) begin
          if (patterns[p][8*j +: 8] != window[l-1-j]) begin
            hit = 1'b0;
          end
        end
        if (hit && LEN_W'(l) == n && n > result.full_len) begin
          result.full_len = n;
        end
        if (hit && LEN_W'(l) < n && HOLD_W'(l) > result.hold) begin
          result.hold = HOLD_W'(l);
        end
      end
    end
  end

endmodule

@@ hw/rtl/stop_string_matcher.sv @@
// ----------------------------------------------------------------------------
// stop_string_matcher: streaming stop-pattern detector with holdback.
// The accepting edge loads the input register; once the result channel is free,
// a later edge loads the result register through the comparator array.
// Throughput one byte per cycle while out_stall is low; the history and counters update as the result loads.
// Synchronous reset clears patterns, lengths, history, counters and both valids.
// ----------------------------------------------------------------------------
module stop_string_matcher import ssm_pkg::*; #(
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input byte channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             text_byte,
  input  logic                   first_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   stop_found,
  output logic [STOP_OFS_W-1:0]  stop_offset,
  output logic [HOLD_W-1:0]      holdback_len,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int HIST = MAX_PATTERN_LEN - 1;

  logic [REG_PATTERNS-1:0][PATTERN_W-1:0] patterns;
  logic [LENGTHS_W-1:0]                   lengths;

  logic                      s1_valid;
  logic [7:0]                s1_byte;
  logic                      s1_first;

  logic [HIST-1:0][7:0]      hist;
  logic [OFFSET_BITS-1:0]    text_length;
  logic                      match_seen;
  logic [OFFSET_BITS-1:0]    best_offset;

  logic                      out_free;
  logic                      s1_fire;
  logic                      in_accept;

  logic [MAX_PATTERN_LEN-1:0][7:0] window;
  logic [OFFSET_BITS-1:0]    pos;
  logic                      seen_eff;
  logic [OFFSET_BITS-1:0]    best_eff;
  logic [LEN_W-1:0]          depth;
  ssm_match_t                mres;
  logic [OFFSET_BITS-1:0]    start;
  logic                      match_seen_next;
  logic [OFFSET_BITS-1:0]    best_offset_next;
  logic [OFFSET_BITS-1:0]    text_length_next;
  logic [OFFSET_BITS+STOP_OFS_W-1:0] best_wide;

  assign cfg_ready = 1'b1;

  assign out_free  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  // A first byte drops the history before the byte is matched
  always_comb begin
    window[0] = s1_byte;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      window[k] = s1_first ? 8'h00 : hist[k-1];
    end
  end

  assign pos      = s1_first ? '0 : text_length;
  assign seen_eff = s1_first ? 1'b0 : match_seen;
  assign best_eff = s1_first ? '0 : best_offset;
  assign depth    = (pos >= OFFSET_BITS'(MAX_PATTERN_LEN - 1)) ? LEN_W'(MAX_PATTERN_LEN)
                                                               : LEN_W'(pos) + LEN_W'(1);

  ssm_match #(
    .NUM_PATTERNS    (NUM_PATTERNS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_match (
    .window   (window),
    .depth    (depth),
    .patterns (patterns),
    .lengths  (lengths),
    .result   (mres)
  );

  // Longest full match gives the earliest start of this byte
  assign start = pos - OFFSET_BITS'(mres.full_len) + OFFSET_BITS'(1);

  always_comb begin
    match_seen_next  = seen_eff;
    best_offset_next = best_eff;
    if (mres.full_len != '0) begin
      match_seen_next = 1'b1;
      if (!seen_eff || start < best_eff) begin
        best_offset_next = start;
      end
    end
  end

  assign text_length_next = (pos == '1) ? pos : pos + OFFSET_BITS'(1);
  assign best_wide        = {{STOP_OFS_W{1'b0}}, best_offset_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      patterns    <= '0;
      lengths     <= '0;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      hist        <= '0;
      text_length <= '0;
      match_seen  <= 1'b0;
      best_offset <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_PATTERN_A:       patterns[0] <= cfg_data;
          CFG_PATTERN_B:       patterns[1] <= cfg_data;
          CFG_PATTERN_C:       patterns[2] <= cfg_data;
          CFG_PATTERN_D:       patterns[3] <= cfg_data;
          CFG_PATTERN_LENGTHS: lengths     <= cfg_data[LENGTHS_W-1:0];
          default: ;
        endcase
      end

      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        out_valid   <= 1'b1;
        hist        <= window[HIST-1:0];
        text_length <= text_length_next;
        match_seen  <= match_seen_next;
        best_offset <= best_offset_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte  <= text_byte;
      s1_first <= first_byte;
    end
    if (s1_fire) begin
      stop_found   <= match_seen_next;
      stop_offset  <= match_seen_next ? best_wide[STOP_OFS_W-1:0] : '0;
      holdback_len <= mres.hold;
    end
  end

endmodule

@@ hw/rtl/ssm_checker.sv @@
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the stop string matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssm_checker import ssm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  stop_found,
  input logic [STOP_OFS_W-1:0] stop_offset,
  input logic [HOLD_W-1:0]     holdback_len
);

  // input held back only while a finished beat waits downstream
  `ASSERT_ALWAYS(a_stall_cause, !in_stall || (out_valid && out_stall), "in_stall without blocked output")

  // stall only follows an accepted or already held beat
  `ASSERT_ALWAYS(a_stall_origin, !in_stall || $past(in_valid && !in_stall) || $past(in_stall), "in_stall with nothing held")

  `ASSERT_ALWAYS(a_offset_clear, !(out_valid && !stop_found) || stop_offset == '0, "offset set without a match")

  // a stalled result beat keeps its payload
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(stop_found) && $stable(stop_offset) && $stable(holdback_len), "stalled result changed")

endmodule

bind stop_string_matcher ssm_checker u_ssm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .stop_found   (stop_found),
  .stop_offset  (stop_offset),
  .holdback_len (holdback_len)
);
